FILE: hdl/dcondo_pkg.sv
// Shared types, constants and helper functions of the digital output command master.
// No dependencies; every other file of the block except the two interfaces uses this package.

package dcondo_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int JOBQ_DEPTH      = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [15:0] TIMEOUT_RST = 16'd100;

    // Frame and answer characters.
    localparam logic [7:0] CH_SOF    = 8'h23;  // '#'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
    localparam logic [7:0] CH_HALF_A = 8'h41;  // 'A'
    localparam logic [7:0] CH_HALF_B = 8'h42;  // 'B'
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ACK    = 8'h3E;  // '>'
    localparam logic [7:0] CH_NAK    = 8'h3F;  // '?'
    localparam logic [7:0] CH_IGN    = 8'h21;  // '!'

    typedef enum logic [1:0] {
        CFG_CHECKSUM = 2'd0,
        CFG_PAUSED   = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TICK = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_TIMEOUT    = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    // Position of a result item within one job: the optional status report, then the frame.
    typedef enum logic [3:0] {
        POS_STATUS  = 4'd0,
        POS_SOF     = 4'd1,
        POS_ADDR_HI = 4'd2,
        POS_ADDR_LO = 4'd3,
        POS_HALF    = 4'd4,
        POS_CHAN    = 4'd5,
        POS_ZERO    = 4'd6,
        POS_STATE   = 4'd7,
        POS_CK_HI   = 4'd8,
        POS_CK_LO   = 4'd9,
        POS_CR      = 4'd10
    } pos_t;

    typedef struct packed {
        logic [7:0] addr;
        logic [3:0] ch;
        logic       on;
    } cmd_t;

    // Work handed from the front to the back for one accepted item.
    typedef struct packed {
        logic    st_valid;
        status_t status;
        logic    frame_valid;
        cmd_t    cmd;
        logic    cks;
    } job_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        d = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
        return d;
    endfunction

    function automatic status_t classify(input logic [7:0] b);
        status_t s;
        if (b == CH_ACK) begin
            s = ST_OK;
        end else if (b == CH_NAK) begin
            s = ST_INVALID;
        end else if (b == CH_IGN) begin
            s = ST_IGNORED;
        end else begin
            s = ST_UNKNOWN;
        end
        return s;
    endfunction

endpackage

FILE: hdl/dcondo_in_if.sv
// Input channel of the digital output command master: valid/ready handshake and item fields.
// Depends on nothing.

interface dcondo_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] dest_address;
    logic [3:0] channel;
    logic       turn_on;
    logic [7:0] rx_byte;

    modport source (output valid, mode, dest_address, channel, turn_on, rx_byte, input ready);
    modport sink   (input valid, mode, dest_address, channel, turn_on, rx_byte, output ready);
endinterface

FILE: hdl/dcondo_out_if.sv
// Result channel of the digital output command master: valid/ready handshake and result fields.
// Depends on nothing.

interface dcondo_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, out_kind, tx_byte, status, last, input ready);
    modport sink   (input valid, out_kind, tx_byte, status, last, output ready);
endinterface

FILE: hdl/dcon_digital_output_master_unit.sv
// Top level of the digital output command master: configuration registers and the
// front, job queue and back. Uses dcondo_pkg, dcondo_in_if, dcondo_out_if and the submodules.
//
// Usage:
//   in_ch carries items: mode 0 queues a set-output command (dest_address, channel,
//   turn_on), mode 1 delivers one received serial byte (rx_byte), mode 2 is one timer tick.
//   out_ch carries result items: frame bytes to transmit (out_kind 0) and status
//   reports (out_kind 1); last marks the final result of one input item.
//   cfg_we/cfg_index/cfg_data write checksum_enable (0), paused (1), timeout_ticks (2);
//   write them only while the block is idle.
// Path: the first result of an item is registered in the job queue and then in the output register.
// Throughput: one result item per cycle while out_ch.ready is high. An item that starts a
//   frame yields 8 to 11 results and keeps the back busy until the last of them is loaded;
//   items without results push no job. The front keeps accepting while the two-entry job queue has room.
// Reset: command queue empty, no answer awaited, checksum off, not paused, timeout 100.
// Stall: while out_ch.ready is low the output register holds, the job queue fills and
//   in_ch.ready falls; nothing is lost.

module dcon_digital_output_master_unit #(
    parameter int QUEUE_DEPTH = dcondo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dcondo_in_if.sink                         in_ch,
    dcondo_out_if.source                      out_ch,
    input  logic                              cfg_we,
    input  logic [dcondo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcondo_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic        cks_en_reg;
    logic        paused_reg;
    logic [15:0] timeout_reg;

    logic             job_push;
    logic             jobq_full;
    logic             job_pop;
    logic             head_valid;
    dcondo_pkg::job_t push_job;
    dcondo_pkg::job_t head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cks_en_reg  <= 1'b0;
            paused_reg  <= 1'b0;
            timeout_reg <= dcondo_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (dcondo_pkg::cfg_idx_t'(cfg_index))
                dcondo_pkg::CFG_CHECKSUM: cks_en_reg  <= cfg_data[0];
                dcondo_pkg::CFG_PAUSED:   paused_reg  <= cfg_data[0];
                dcondo_pkg::CFG_TIMEOUT:  timeout_reg <= cfg_data[15:0];
                default:                  paused_reg  <= paused_reg;
            endcase
        end
    end

    dcondo_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .cks_en        (cks_en_reg),
        .paused        (paused_reg),
        .timeout_ticks (timeout_reg),
        .jobq_full     (jobq_full),
        .job_push      (job_push),
        .job           (push_job)
    );

    dcondo_jobq u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .full       (jobq_full),
        .pop        (job_pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    dcondo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .pop       (job_pop),
        .out_ch    (out_ch)
    );

endmodule

FILE: hdl/dcondo_front.sv
// Front part: accepts items, keeps the command queue and the answer/timeout state,
// and hands one job per productive item to the job queue. Uses dcondo_pkg, dcondo_in_if.

module dcondo_front #(
    parameter int QUEUE_DEPTH = dcondo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    dcondo_in_if.sink          in_ch,
    input  logic               cks_en,
    input  logic               paused,
    input  logic [15:0]        timeout_ticks,
    input  logic               jobq_full,
    output logic               job_push,
    output dcondo_pkg::job_t   job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    dcondo_pkg::cmd_t mem [QUEUE_DEPTH];
    dcondo_pkg::cmd_t rdata_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          awaiting_reg, awaiting_next;
    logic          have_first_reg, have_first_next;
    logic [7:0]    first_byte_reg, first_byte_next;
    logic [15:0]   ticks_reg, ticks_next;

    logic               fire;
    logic               full;
    logic               push;
    logic               send;
    logic               mem_wr;
    logic               mem_pop;
    logic               st_valid;
    dcondo_pkg::status_t st;
    logic [7:0]         rx_first;
    logic [15:0]        ticks_inc;
    logic [CW-1:0]      count_after;
    dcondo_pkg::cmd_t   incoming;
    dcondo_pkg::cmd_t   send_cmd;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        n = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
        return n;
    endfunction

    assign fire        = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !jobq_full;
    assign full        = (count_reg == CW'(QUEUE_DEPTH));

    assign incoming.addr = in_ch.dest_address;
    assign incoming.ch   = in_ch.channel;
    assign incoming.on   = in_ch.turn_on;

    assign rx_first  = have_first_reg ? first_byte_reg : in_ch.rx_byte;
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    always_comb
    begin
        st_valid        = 1'b0;
        st              = dcondo_pkg::ST_OK;
        push            = 1'b0;
        awaiting_next   = awaiting_reg;
        have_first_next = have_first_reg;
        first_byte_next = first_byte_reg;
        ticks_next      = ticks_reg;

        if (fire)
        begin
            case (dcondo_pkg::mode_t'(in_ch.mode))
                dcondo_pkg::MODE_CMD:
                begin
                    if (full)
                    begin
                        st_valid = 1'b1;
                        st       = dcondo_pkg::ST_QUEUE_FULL;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                dcondo_pkg::MODE_RX:
                begin
                    if (awaiting_reg)
                    begin
                        have_first_next = 1'b1;
                        first_byte_next = rx_first;
                        if (in_ch.rx_byte == dcondo_pkg::CH_CR)
                        begin
                            st_valid      = 1'b1;
                            st            = dcondo_pkg::classify(rx_first);
                            awaiting_next = 1'b0;
                        end
                    end
                end
                dcondo_pkg::MODE_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= timeout_ticks)
                        begin
                            st_valid      = 1'b1;
                            st            = dcondo_pkg::ST_TIMEOUT;
                            awaiting_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    st_valid = 1'b0;
                end
            endcase
        end

        count_after = count_reg + CW'(push);
        send        = fire && !awaiting_next && !paused && (count_after != '0);

        if (send)
        begin
            awaiting_next   = 1'b1;
            have_first_next = 1'b0;
            first_byte_next = 8'h00;
            ticks_next      = 16'h0000;
        end
    end

    // When the queue is empty and a frame is sent, the just-pushed command goes straight to the frame, never stored.
    assign send_cmd = (count_reg == '0) ? incoming : rdata_reg;
    assign mem_wr   = push && !(send && (count_reg == '0));
    assign mem_pop  = send && (count_reg != '0);

    always_comb
    begin
        head_next  = mem_pop ? next_ptr(head_reg) : head_reg;
        tail_next  = mem_wr ? next_ptr(tail_reg) : tail_reg;
        count_next = count_reg;
        if (mem_wr && !mem_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (mem_pop && !mem_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        job_push        = st_valid || send;
        job.st_valid    = st_valid;
        job.status      = st;
        job.frame_valid = send;
        job.cmd         = send_cmd;
        job.cks         = cks_en;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[tail_reg] <= incoming;
        end
    end

    // The read port registers the entry at the next head pointer, so it presents the oldest stored command.
    always_ff @(posedge clk)
    begin
        if (mem_wr && (tail_reg == head_next))
        begin
            rdata_reg <= incoming;
        end
        else
        begin
            rdata_reg <= mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            awaiting_reg   <= 1'b0;
            have_first_reg <= 1'b0;
            first_byte_reg <= 8'h00;
            ticks_reg      <= 16'h0000;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            awaiting_reg   <= awaiting_next;
            have_first_reg <= have_first_next;
            first_byte_reg <= first_byte_next;
            ticks_reg      <= ticks_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("command queue count above depth");

    a_send_arms: assert property (@(posedge clk) disable iff (!rst_n)
        send |=> (awaiting_reg && (ticks_reg == 16'h0000) && !have_first_reg))
        else $error("sent frame did not arm answer wait");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_ch.mode == dcondo_pkg::MODE_CMD) && full)
        |-> (job_push && job.st_valid && (job.status == dcondo_pkg::ST_QUEUE_FULL)))
        else $error("full queue did not reject command");
`endif

endmodule

FILE: hdl/dcondo_jobq.sv
// Short job queue between the front and the back, so that each side can stall alone.
// Uses dcondo_pkg.

module dcondo_jobq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dcondo_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output dcondo_pkg::job_t head_job,
    output logic             head_valid
);

    localparam int PW = (dcondo_pkg::JOBQ_DEPTH > 1) ? $clog2(dcondo_pkg::JOBQ_DEPTH) : 1;
    localparam int CW = $clog2(dcondo_pkg::JOBQ_DEPTH + 1);

    dcondo_pkg::job_t q_mem [dcondo_pkg::JOBQ_DEPTH];

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        n = (p == PW'(dcondo_pkg::JOBQ_DEPTH - 1)) ? '0 : p + PW'(1);
        return n;
    endfunction

    assign full       = (count_reg == CW'(dcondo_pkg::JOBQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = q_mem[head_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        head_next  = do_pop ? next_ptr(head_reg) : head_reg;
        tail_next  = do_push ? next_ptr(tail_reg) : tail_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[tail_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/dcondo_back.sv
// Back part: turns the job at the head of the job queue into result items, one per cycle,
// while out_ch is not stalled, through an output register. Uses dcondo_pkg, dcondo_out_if.

module dcondo_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dcondo_pkg::job_t job,
    input  logic             job_valid,
    output logic             pop,
    dcondo_out_if.source     out_ch
);

    dcondo_pkg::pos_t pos_reg, pos_next;
    dcondo_pkg::pos_t eff_pos;
    logic [7:0]       sum_reg, sum_next;

    logic       out_valid_reg, out_valid_next;
    logic       kind_reg;
    logic [7:0] tx_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    logic       load;
    logic       is_last;
    logic [7:0] byte_w;

    // A job without a status report starts directly at the frame.
    assign eff_pos = ((pos_reg == dcondo_pkg::POS_STATUS) && !job.st_valid)
                     ? dcondo_pkg::POS_SOF : pos_reg;

    always_comb
    begin
        case (eff_pos)
            dcondo_pkg::POS_SOF:     byte_w = dcondo_pkg::CH_SOF;
            dcondo_pkg::POS_ADDR_HI: byte_w = dcondo_pkg::hex_digit(job.cmd.addr[7:4]);
            dcondo_pkg::POS_ADDR_LO: byte_w = dcondo_pkg::hex_digit(job.cmd.addr[3:0]);
            dcondo_pkg::POS_HALF:
                byte_w = job.cmd.ch[3] ? dcondo_pkg::CH_HALF_B : dcondo_pkg::CH_HALF_A;
            dcondo_pkg::POS_CHAN:    byte_w = dcondo_pkg::CH_ZERO + {5'b0, job.cmd.ch[2:0]};
            dcondo_pkg::POS_ZERO:    byte_w = dcondo_pkg::CH_ZERO;
            dcondo_pkg::POS_STATE:
                byte_w = job.cmd.on ? dcondo_pkg::CH_ONE : dcondo_pkg::CH_ZERO;
            dcondo_pkg::POS_CK_HI:   byte_w = dcondo_pkg::hex_digit(sum_reg[7:4]);
            dcondo_pkg::POS_CK_LO:   byte_w = dcondo_pkg::hex_digit(sum_reg[3:0]);
            dcondo_pkg::POS_CR:      byte_w = dcondo_pkg::CH_CR;
            default:                 byte_w = 8'h00;
        endcase
    end

    assign is_last = (eff_pos == dcondo_pkg::POS_STATUS) ? !job.frame_valid
                                                         : (eff_pos == dcondo_pkg::POS_CR);
    assign load    = job_valid && (!out_valid_reg || out_ch.ready);
    assign pop     = load && is_last;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (load)
        begin
            if (is_last)
            begin
                pos_next = dcondo_pkg::POS_STATUS;
            end
            else
            begin
                case (eff_pos)
                    dcondo_pkg::POS_STATUS: pos_next = dcondo_pkg::POS_SOF;
                    dcondo_pkg::POS_STATE:
                        pos_next = job.cks ? dcondo_pkg::POS_CK_HI : dcondo_pkg::POS_CR;
                    default: pos_next = dcondo_pkg::pos_t'(4'(eff_pos) + 4'd1);
                endcase
            end

            // The checksum runs over the frame characters before it.
            if (eff_pos == dcondo_pkg::POS_SOF)
            begin
                sum_next = byte_w;
            end
            else if ((eff_pos > dcondo_pkg::POS_SOF) && (eff_pos <= dcondo_pkg::POS_STATE))
            begin
                sum_next = sum_reg + byte_w;
            end
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (load)
        begin
            kind_reg   <= (eff_pos == dcondo_pkg::POS_STATUS);
            tx_reg     <= byte_w;
            status_reg <= (eff_pos == dcondo_pkg::POS_STATUS) ? job.status
                                                              : dcondo_pkg::ST_OK;
            last_reg   <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= dcondo_pkg::POS_STATUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_kind = kind_reg;
    assign out_ch.tx_byte  = tx_reg;
    assign out_ch.status   = status_reg;
    assign out_ch.last     = last_reg;

`ifndef NO_ASSERTIONS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= dcondo_pkg::POS_CR)
        else $error("frame position out of range");

    a_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != dcondo_pkg::POS_STATUS) |-> job_valid)
        else $error("job left the queue before its last item");

    a_cks_only: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && ((pos_reg == dcondo_pkg::POS_CK_HI) || (pos_reg == dcondo_pkg::POS_CK_LO)))
        |-> job.cks)
        else $error("checksum emitted for a job without checksum");
`endif

endmodule

FILE: bench/dcon_digital_output_master_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of dcon_digital_output_master_unit: directed and random items drive the block.
// A scoreboard predicts every frame byte and status report. Depends on dcondo_pkg,
// dcondo_in_if, dcondo_out_if and the block's RTL.

module dcon_digital_output_master_unit_tb;

    localparam int CMD_DEPTH     = dcondo_pkg::QUEUE_DEPTH_DEF;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int STUCK_LIMIT   = 2000;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [7:0] HEX_LETTER = 8'h41;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] dest_address;
        logic [3:0] channel;
        logic       turn_on;
        logic [7:0] rx_byte;
    } link_item_t;

    typedef struct packed {
        logic                out_kind;
        logic [7:0]          tx_byte;
        dcondo_pkg::status_t status;
        logic                last;
    } link_result_t;

    class dout_scoreboard;
        dcondo_pkg::cmd_t pending_cmds[$];
        link_result_t     expected[$];
        logic             checksum_on;
        logic             hold_queue;
        logic [15:0]      timeout_limit;
        logic             awaiting;
        logic             got_first;
        logic [7:0]       first_byte;
        logic [15:0]      ticks;
        int               errors;

        function new();
            checksum_on   = 1'b0;
            hold_queue    = 1'b0;
            timeout_limit = dcondo_pkg::TIMEOUT_RST;
            awaiting      = 1'b0;
            got_first     = 1'b0;
            first_byte    = 8'h00;
            ticks         = 16'd0;
            errors        = 0;
        endfunction

        function void write_reg(dcondo_pkg::cfg_idx_t idx, logic [15:0] data);
            case (idx)
                dcondo_pkg::CFG_CHECKSUM: checksum_on   = data[0];
                dcondo_pkg::CFG_PAUSED:   hold_queue    = data[0];
                dcondo_pkg::CFG_TIMEOUT:  timeout_limit = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] nibble_char(logic [3:0] v);
            return (v < 4'd10) ? dcondo_pkg::CH_ZERO + {4'h0, v}
                               : HEX_LETTER + {4'h0, v} - 8'd10;
        endfunction

        function void push_result(logic kind, logic [7:0] tx, dcondo_pkg::status_t st);
            link_result_t r;
            r.out_kind = kind;
            r.tx_byte  = tx;
            r.status   = st;
            r.last     = 1'b0;
            expected.push_back(r);
        endfunction

        function void emit_frame();
            dcondo_pkg::cmd_t c;
            logic [7:0]       frame[$];
            logic [7:0]       sum;
            c = pending_cmds.pop_front();
            frame.push_back(dcondo_pkg::CH_SOF);
            frame.push_back(nibble_char(c.addr[7:4]));
            frame.push_back(nibble_char(c.addr[3:0]));
            frame.push_back(c.ch[3] ? dcondo_pkg::CH_HALF_B : dcondo_pkg::CH_HALF_A);
            // Only the position within the half goes on the wire.
            frame.push_back(dcondo_pkg::CH_ZERO + {5'd0, c.ch[2:0]});
            frame.push_back(dcondo_pkg::CH_ZERO);
            frame.push_back(c.on ? dcondo_pkg::CH_ONE : dcondo_pkg::CH_ZERO);
            if (checksum_on)
            begin
                sum = 8'h00;
                foreach (frame[i])
                    sum = sum + frame[i];
                frame.push_back(nibble_char(sum[7:4]));
                frame.push_back(nibble_char(sum[3:0]));
            end
            frame.push_back(dcondo_pkg::CH_CR);
            foreach (frame[i])
                push_result(1'b0, frame[i], dcondo_pkg::ST_OK);
            awaiting   = 1'b1;
            got_first  = 1'b0;
            first_byte = 8'h00;
            ticks      = 16'd0;
        endfunction

        // Returns 1 for every command item and for a received byte or tick while an answer is awaited.
        function bit note_input(link_item_t it);
            bit                  useful;
            int                  first_new;
            dcondo_pkg::cmd_t    c;
            dcondo_pkg::status_t st;
            useful    = 1'b0;
            first_new = expected.size();
            case (it.mode)
                dcondo_pkg::MODE_CMD:
                begin
                    useful = 1'b1;
                    if (pending_cmds.size() >= CMD_DEPTH)
                        push_result(1'b1, 8'h00, dcondo_pkg::ST_QUEUE_FULL);
                    else
                    begin
                        c.addr = it.dest_address;
                        c.ch   = it.channel;
                        c.on   = it.turn_on;
                        pending_cmds.push_back(c);
                    end
                end
                dcondo_pkg::MODE_RX:
                    if (awaiting)
                    begin
                        useful = 1'b1;
                        if (!got_first)
                        begin
                            first_byte = it.rx_byte;
                            got_first  = 1'b1;
                        end
                        if (it.rx_byte == dcondo_pkg::CH_CR)
                        begin
                            case (first_byte)
                                dcondo_pkg::CH_ACK: st = dcondo_pkg::ST_OK;
                                dcondo_pkg::CH_NAK: st = dcondo_pkg::ST_INVALID;
                                dcondo_pkg::CH_IGN: st = dcondo_pkg::ST_IGNORED;
                                default:            st = dcondo_pkg::ST_UNKNOWN;
                            endcase
                            push_result(1'b1, 8'h00, st);
                            awaiting = 1'b0;
                        end
                    end
                dcondo_pkg::MODE_TICK:
                    if (awaiting)
                    begin
                        useful = 1'b1;
                        if (ticks != 16'hFFFF)
                            ticks = ticks + 16'd1;
                        if (ticks >= timeout_limit)
                        begin
                            push_result(1'b1, 8'h00, dcondo_pkg::ST_TIMEOUT);
                            awaiting = 1'b0;
                        end
                    end
                default: ;
            endcase
            if (!awaiting && !hold_queue && pending_cmds.size() > 0)
                emit_frame();
            if (expected.size() > first_new)
                expected[expected.size() - 1].last = 1'b1;
            return useful;
        endfunction

        function void check_result(link_result_t got);
            link_result_t want;
            bit           bad;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d byte %h status %0d last %0d",
                         $time, got.out_kind, got.tx_byte, got.status, got.last);
                errors++;
                return;
            end
            want = expected.pop_front();
            bad  = 1'b0;
            if (got.out_kind !== want.out_kind)
            begin
                $display("%0t: out_kind expected %0d, got %0d", $time, want.out_kind, got.out_kind);
                bad = 1'b1;
            end
            if (got.tx_byte !== want.tx_byte)
            begin
                $display("%0t: tx_byte expected %h, got %h", $time, want.tx_byte, got.tx_byte);
                bad = 1'b1;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                bad = 1'b1;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
                bad = 1'b1;
            end
            if (bad)
                errors++;
        endfunction

        function void report_leftovers();
            if (expected.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time, expected.size());
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [dcondo_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dcondo_pkg::CFG_DATA_W-1:0] cfg_data;

    dcondo_in_if  in_ch();
    dcondo_out_if out_ch();

    dout_scoreboard sb;
    link_result_t   observed;
    bit             calm = 1'b0;
    bit             hold_req = 1'b0;
    int             hold_left = 0;
    int             counted_items = 0;
    int             stuck = 0;

    dcon_digital_output_master_unit #(
        .QUEUE_DEPTH(CMD_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic link_item_t cmd_item(logic [7:0] addr, logic [3:0] ch, logic on);
        link_item_t it;
        it              = '0;
        it.mode         = dcondo_pkg::MODE_CMD;
        it.dest_address = addr;
        it.channel      = ch;
        it.turn_on      = on;
        return it;
    endfunction

    function automatic link_item_t rx_item(logic [7:0] b);
        link_item_t it;
        it         = '0;
        it.mode    = dcondo_pkg::MODE_RX;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic link_item_t tick_item();
        link_item_t it;
        it      = '0;
        it.mode = dcondo_pkg::MODE_TICK;
        return it;
    endfunction

    function automatic link_item_t spare_item();
        link_item_t it;
        it              = '0;
        it.mode         = MODE_SPARE;
        it.dest_address = 8'($urandom_range(0, 255));
        it.rx_byte      = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic logic [7:0] lead_byte();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0:       return dcondo_pkg::CH_ACK;
            1:       return dcondo_pkg::CH_NAK;
            2:       return dcondo_pkg::CH_IGN;
            3:       return dcondo_pkg::CH_CR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(link_item_t it);
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= it.mode;
        in_ch.dest_address <= it.dest_address;
        in_ch.channel      <= it.channel;
        in_ch.turn_on      <= it.turn_on;
        in_ch.rx_byte      <= it.rx_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (sb.note_input(it))
            counted_items++;
        @(negedge clk);
    endtask

    // Waits until every predicted result has come out, then lets the back run dry.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(logic cks, logic pause, logic [15:0] tmo);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= dcondo_pkg::CFG_CHECKSUM;
        cfg_data  <= {15'd0, cks};
        @(negedge clk);
        cfg_index <= dcondo_pkg::CFG_PAUSED;
        cfg_data  <= {15'd0, pause};
        @(negedge clk);
        cfg_index <= dcondo_pkg::CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(dcondo_pkg::CFG_CHECKSUM, {15'd0, cks});
        sb.write_reg(dcondo_pkg::CFG_PAUSED, {15'd0, pause});
        sb.write_reg(dcondo_pkg::CFG_TIMEOUT, tmo);
    endtask

    // Mostly complete exchanges (command, optional ticks, answer up to CR), some noise.
    task automatic random_phase(int target);
        int start;
        int pick;
        start = counted_items;
        while (counted_items - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_item(cmd_item(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                   1'($urandom_range(0, 1))));
                repeat ($urandom_range(0, 2)) send_item(tick_item());
                send_item(rx_item(lead_byte()));
                repeat ($urandom_range(0, 2)) send_item(rx_item(8'($urandom_range(0, 255))));
                send_item(rx_item(dcondo_pkg::CH_CR));
            end
            else if (pick < 75)
                send_item(cmd_item(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                   1'($urandom_range(0, 1))));
            else if (pick < 85)
                send_item(rx_item(8'($urandom_range(0, 255))));
            else if (pick < 95)
                send_item(tick_item());
            else
                send_item(spare_item());
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (calm)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            observed.out_kind = out_ch.out_kind;
            observed.tx_byte  = out_ch.tx_byte;
            observed.status   = dcondo_pkg::status_t'(out_ch.status);
            observed.last     = out_ch.last;
            sb.check_result(observed);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
            $display("dcon_digital_output_master_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= dcondo_pkg::CFG_CHECKSUM;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= dcondo_pkg::MODE_CMD;
        in_ch.dest_address <= 8'h00;
        in_ch.channel      <= 4'h0;
        in_ch.turn_on      <= 1'b0;
        in_ch.rx_byte      <= 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: each answer class, CR as the first byte, idle bytes and ticks.
        send_item(cmd_item(8'h00, 4'd0, 1'b0));
        send_item(rx_item(dcondo_pkg::CH_ACK));
        send_item(rx_item(dcondo_pkg::CH_CR));
        send_item(rx_item(8'hFF));
        send_item(tick_item());
        send_item(spare_item());
        send_item(cmd_item(8'hFF, 4'd15, 1'b1));
        send_item(rx_item(dcondo_pkg::CH_CR));
        send_item(cmd_item(8'hA5, 4'd7, 1'b1));
        send_item(rx_item(dcondo_pkg::CH_NAK));
        send_item(rx_item(8'h00));
        send_item(rx_item(dcondo_pkg::CH_CR));
        send_item(cmd_item(8'h5A, 4'd8, 1'b0));
        send_item(rx_item(dcondo_pkg::CH_IGN));
        send_item(rx_item(dcondo_pkg::CH_CR));

        // Paused: the ninth command finds the queue full.
        configure(1'b1, 1'b1, 16'd0);
        for (int i = 0; i < CMD_DEPTH + 1; i++)
            send_item(cmd_item(8'(i * 29 + 3), 4'(i * 5), 1'(i)));
        send_item(spare_item());

        // Zero timeout: every awaited answer expires at its first tick.
        configure(1'b1, 1'b0, 16'd0);
        random_phase(10);

        configure(1'b0, 1'b0, 16'hFFFF);
        hold_req = 1'b1;
        random_phase(12);

        configure(1'($urandom_range(0, 1)), 1'b0, 16'($urandom_range(1, 8)));
        calm = 1'b1;
        random_phase(16);
        calm = 1'b0;

        configure(1'b1, 1'b0, 16'd1);
        random_phase(11);

        configure(1'($urandom_range(0, 1)), 1'b0, 16'($urandom_range(2, 40)));
        random_phase(11);

        settle();
        sb.report_leftovers();
        if (sb.errors == 0)
            $display("dcon_digital_output_master_unit_tb: PASS");
        else
            $display("dcon_digital_output_master_unit_tb: FAIL");
        $finish;
    end

endmodule
